// ===== rtl/ordered_list_store_core_defines.svh =====
`ifndef ORDERED_LIST_STORE_CORE_DEFINES_SVH
`define ORDERED_LIST_STORE_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define OLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define OLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ols_pkg.sv =====
`timescale 1ns / 1ps

package ols_pkg;

    localparam int OLS_CAPACITY   = 256;
    localparam int OLS_ITEM_WIDTH = 32;

    localparam int OLS_OP_W    = 3;
    localparam int OLS_POS_W   = 9;
    localparam int OLS_VALUE_W = 32;
    localparam int OLS_COUNT_W = 9;

    localparam logic [OLS_POS_W-1:0] OLS_IDX_NONE = '1;

    typedef enum logic [OLS_OP_W-1:0] {
        OP_INSERT_AT     = 3'd0,
        OP_INSERT_SORTED = 3'd1,
        OP_ERASE_AT      = 3'd2,
        OP_REMOVE_ALL    = 3'd3,
        OP_GET           = 3'd4,
        OP_SET           = 3'd5,
        OP_FIND          = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_PREP_UP,
        S_UP,
        S_DOWN,
        S_PACK,
        S_GET,
        S_GET_DONE,
        S_RESULT
    } t_state;

    // what the memory sweep does this cycle
    typedef enum logic [2:0] {
        M_NONE,
        M_SEARCH,
        M_UP,
        M_DOWN,
        M_PACK,
        M_GET
    } t_mode;

    // which result the datapath loads
    typedef enum logic [2:0] {
        RES_NONE,
        RES_FAIL,
        RES_POS,
        RES_HIT,
        RES_READ,
        RES_PACK
    } t_res;

    typedef struct packed {
        logic  capture;
        logic  init;
        logic  finish;
        logic  write_set;
        logic  set_pos_hit;
        logic  set_pos_end;
        t_mode mode;
        t_res  res;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic pos_le;
        logic pos_lt;
        logic more_fwd;
        logic more_up;
        logic rv;
        logic hit;
    } t_sts;

endpackage

// ===== rtl/ols_ctrl.sv =====
`timescale 1ns / 1ps

module ols_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ols_pkg::t_sts i_sts,
    output ols_pkg::t_cmd o_cmd
);
    import ols_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.mode  = M_NONE;
        o_cmd.res   = RES_NONE;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.res = RES_FAIL;
                n_state   = S_RESULT;
                case (i_sts.op)
                    OP_INSERT_AT: begin
                        if (!i_sts.full && i_sts.pos_le) begin
                            o_cmd.res = RES_NONE;
                            n_state   = S_PREP_UP;
                        end
                    end
                    OP_INSERT_SORTED: begin
                        if (!i_sts.full) begin
                            o_cmd.res  = RES_NONE;
                            o_cmd.mode = M_SEARCH;
                            o_cmd.init = 1'b1;
                            n_state    = S_SEARCH;
                        end
                    end
                    OP_ERASE_AT: begin
                        if (i_sts.pos_lt) begin
                            o_cmd.res  = RES_NONE;
                            o_cmd.mode = M_DOWN;
                            o_cmd.init = 1'b1;
                            n_state    = S_DOWN;
                        end
                    end
                    OP_REMOVE_ALL: begin
                        o_cmd.res  = RES_NONE;
                        o_cmd.mode = M_PACK;
                        o_cmd.init = 1'b1;
                        n_state    = S_PACK;
                    end
                    OP_GET: begin
                        if (i_sts.pos_lt) begin
                            o_cmd.res = RES_NONE;
                            n_state   = S_GET;
                        end
                    end
                    OP_SET: begin
                        if (i_sts.pos_lt) begin
                            o_cmd.write_set = 1'b1;
                            o_cmd.res       = RES_POS;
                        end
                    end
                    OP_FIND: begin
                        o_cmd.res  = RES_NONE;
                        o_cmd.mode = M_SEARCH;
                        o_cmd.init = 1'b1;
                        n_state    = S_SEARCH;
                    end
                    default: begin
                        o_cmd.res = RES_FAIL;
                    end
                endcase
            end
            S_SEARCH: begin
                o_cmd.mode = M_SEARCH;
                if (i_sts.hit) begin
                    if (i_sts.op == OP_INSERT_SORTED) begin
                        o_cmd.set_pos_hit = 1'b1;
                        n_state           = S_PREP_UP;
                    end else begin
                        o_cmd.res = RES_HIT;
                        n_state   = S_RESULT;
                    end
                end else if (!i_sts.more_fwd && !i_sts.rv) begin
                    if (i_sts.op == OP_INSERT_SORTED) begin
                        // no entry greater than or equal to the value found: append at the end
                        o_cmd.set_pos_end = 1'b1;
                        n_state           = S_PREP_UP;
                    end else begin
                        o_cmd.res = RES_FAIL;
                        n_state   = S_RESULT;
                    end
                end
            end
            S_PREP_UP: begin
                o_cmd.mode = M_UP;
                o_cmd.init = 1'b1;
                n_state    = S_UP;
            end
            S_UP: begin
                o_cmd.mode = M_UP;
                if (!i_sts.more_up && !i_sts.rv) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.res    = RES_POS;
                    n_state      = S_RESULT;
                end
            end
            S_DOWN: begin
                o_cmd.mode = M_DOWN;
                if (!i_sts.more_fwd && !i_sts.rv) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.res    = RES_POS;
                    n_state      = S_RESULT;
                end
            end
            S_PACK: begin
                o_cmd.mode = M_PACK;
                if (!i_sts.more_fwd && !i_sts.rv) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.res    = RES_PACK;
                    n_state      = S_RESULT;
                end
            end
            S_GET: begin
                o_cmd.mode = M_GET;
                n_state    = S_GET_DONE;
            end
            S_GET_DONE: begin
                o_cmd.res = RES_READ;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ols_dp.sv =====
`timescale 1ns / 1ps

module ols_dp #(
    parameter int CAPACITY   = ols_pkg::OLS_CAPACITY,
    parameter int ITEM_WIDTH = ols_pkg::OLS_ITEM_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ols_pkg::t_cmd                          i_cmd,
    output ols_pkg::t_sts                          o_sts,
    input  logic        [ols_pkg::OLS_OP_W-1:0]    i_opcode,
    input  logic        [ols_pkg::OLS_POS_W-1:0]   i_position,
    input  logic signed [ols_pkg::OLS_VALUE_W-1:0] i_item_value,
    output logic                                   o_ok,
    output logic signed [ols_pkg::OLS_POS_W-1:0]   o_result_index,
    output logic signed [ols_pkg::OLS_VALUE_W-1:0] o_read_value,
    output logic        [ols_pkg::OLS_COUNT_W-1:0] o_removed_count,
    output logic        [ols_pkg::OLS_COUNT_W-1:0] o_item_count,
    output logic                                   o_is_empty
);
    import ols_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > OLS_POS_W) ? CW : OLS_POS_W;

    logic signed [ITEM_WIDTH-1:0] r_mem [CAPACITY];

    logic        [CW-1:0]          r_count;
    t_op                           r_op;
    logic        [PW-1:0]          r_pos;
    logic signed [ITEM_WIDTH-1:0]  r_val;
    logic        [CW-1:0]          r_rd_ptr;
    logic        [CW-1:0]          r_wr_ptr;
    logic                          r_rv;
    logic        [IW-1:0]          r_ra;
    logic signed [ITEM_WIDTH-1:0]  r_rdata;

    logic                          r_ok;
    logic        [OLS_POS_W-1:0]   r_idx;
    logic signed [OLS_VALUE_W-1:0] r_rd;
    logic        [OLS_COUNT_W-1:0] r_removed;

    logic                          rd_en;
    logic        [IW-1:0]          rd_addr;
    logic        [CW-1:0]          n_rd_ptr;
    logic                          wr_en;
    logic        [IW-1:0]          wr_addr;
    logic signed [ITEM_WIDTH-1:0]  wr_data;
    logic        [CW-1:0]          pos_c;
    logic        [CW-1:0]          rd_dec;
    logic        [CW-1:0]          removed;
    logic                          keep;
    logic                          more_fwd;
    logic                          more_up;

    assign pos_c    = r_pos[CW-1:0];
    assign rd_dec   = r_rd_ptr - 1'b1;
    assign removed  = r_count - r_wr_ptr;
    assign keep     = (r_rdata != r_val);
    assign more_fwd = (r_rd_ptr < r_count);
    assign more_up  = (r_rd_ptr > pos_c);

    // read side of the sweep: one entry per cycle
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_rd_ptr[IW-1:0];
        n_rd_ptr = r_rd_ptr;
        if (!i_cmd.init) begin
            case (i_cmd.mode)
                M_SEARCH, M_PACK, M_DOWN: begin
                    if (more_fwd) begin
                        rd_en    = 1'b1;
                        n_rd_ptr = r_rd_ptr + 1'b1;
                    end
                end
                M_UP: begin
                    // walks downward from the top entry
                    if (more_up) begin
                        rd_en    = 1'b1;
                        rd_addr  = rd_dec[IW-1:0];
                        n_rd_ptr = rd_dec;
                    end
                end
                M_GET: begin
                    rd_en   = 1'b1;
                    rd_addr = r_pos[IW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // write side: up/down sweeps put the entry read last cycle one place over
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pos[IW-1:0];
        wr_data = r_val;
        if (i_cmd.write_set) begin
            wr_en = 1'b1;
        end else if (!i_cmd.init) begin
            case (i_cmd.mode)
                M_UP: begin
                    if (r_rv) begin
                        wr_en   = 1'b1;
                        wr_addr = r_ra + 1'b1;
                        wr_data = r_rdata;
                    end else if (i_cmd.finish) begin
                        wr_en = 1'b1;
                    end
                end
                M_DOWN: begin
                    if (r_rv) begin
                        wr_en   = 1'b1;
                        wr_addr = r_ra - 1'b1;
                        wr_data = r_rdata;
                    end
                end
                M_PACK: begin
                    // compaction: survivors are copied down to the write pointer
                    if (r_rv && keep) begin
                        wr_en   = 1'b1;
                        wr_addr = r_wr_ptr[IW-1:0];
                        wr_data = r_rdata;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_rv <= rd_en;
            if (i_cmd.finish) begin
                case (i_cmd.mode)
                    M_UP:    r_count <= r_count + 1'b1;
                    M_DOWN:  r_count <= r_count - 1'b1;
                    M_PACK:  r_count <= r_wr_ptr;
                    default: r_count <= r_count;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra <= rd_addr;
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_opcode);
            r_pos <= PW'(i_position);
            r_val <= ITEM_WIDTH'(i_item_value);
        end else if (i_cmd.set_pos_hit) begin
            r_pos <= PW'(r_ra);
        end else if (i_cmd.set_pos_end) begin
            r_pos <= PW'(r_count);
        end

        if (i_cmd.init) begin
            case (i_cmd.mode)
                M_SEARCH, M_PACK: begin
                    r_rd_ptr <= '0;
                    r_wr_ptr <= '0;
                end
                M_UP:    r_rd_ptr <= r_count;
                M_DOWN:  r_rd_ptr <= pos_c + 1'b1;
                default: r_rd_ptr <= r_rd_ptr;
            endcase
        end else begin
            if (rd_en) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_cmd.mode == M_PACK && wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
        end

        case (i_cmd.res)
            RES_FAIL: begin
                r_ok      <= 1'b0;
                r_idx     <= OLS_IDX_NONE;
                r_rd      <= '0;
                r_removed <= '0;
            end
            RES_POS: begin
                r_ok      <= 1'b1;
                r_idx     <= OLS_POS_W'(r_pos);
                r_rd      <= '0;
                r_removed <= '0;
            end
            RES_HIT: begin
                r_ok      <= 1'b1;
                r_idx     <= OLS_POS_W'(r_ra);
                r_rd      <= '0;
                r_removed <= '0;
            end
            RES_READ: begin
                r_ok      <= 1'b1;
                r_idx     <= OLS_POS_W'(r_pos);
                r_rd      <= OLS_VALUE_W'(r_rdata);
                r_removed <= '0;
            end
            RES_PACK: begin
                r_ok      <= (removed != '0);
                r_idx     <= OLS_IDX_NONE;
                r_rd      <= '0;
                r_removed <= OLS_COUNT_W'(removed);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.full     = (r_count == CW'(CAPACITY));
        o_sts.pos_le   = (r_pos <= PW'(r_count));
        o_sts.pos_lt   = (r_pos < PW'(r_count));
        o_sts.more_fwd = more_fwd;
        o_sts.more_up  = more_up;
        o_sts.rv       = r_rv;
        o_sts.hit      = r_rv && ((r_op == OP_INSERT_SORTED) ? (r_val <= r_rdata)
                                                            : (r_val == r_rdata));
    end

    assign o_ok            = r_ok;
    assign o_result_index  = r_idx;
    assign o_read_value    = r_rd;
    assign o_removed_count = r_removed;
    assign o_item_count    = OLS_COUNT_W'(r_count);
    assign o_is_empty      = (r_count == '0);

endmodule

// ===== rtl/ordered_list_store_core.sv =====
// Ordered list store: a list of up to CAPACITY signed items with insert_at,
// insert_sorted, erase_at, remove_all, get, set and find operations.
// Input channel: i_in_valid / o_in_stall with opcode, position and value;
// a transfer happens on a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall, one result per input item
// (ok, index or -1, read value, removed count, item count, empty flag).
// One item is worked on at a time. Set and every failing range or full check
// need no memory pass; get does one memory read, find scans up to the item
// count, erase_at and remove_all move or scan entries, insert_at moves
// entries and insert_sorted searches and then moves entries. The item memory
// does one read and one write per cycle and moves one entry per cycle.
// After a result transfer the block takes a new item on the next cycle.
// While the receiver stalls, the result holds on the outputs and the
// input channel stays stalled.
// Reset (i_rst_n low, synchronous) empties the list at once; no clearing
// pass is needed, as entries at or above the item count are never read.
`timescale 1ns / 1ps
`include "ordered_list_store_core_defines.svh"

module ordered_list_store_core #(
    parameter int CAPACITY   = ols_pkg::OLS_CAPACITY,
    parameter int ITEM_WIDTH = ols_pkg::OLS_ITEM_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic        [ols_pkg::OLS_OP_W-1:0]    i_opcode,
    input  logic        [ols_pkg::OLS_POS_W-1:0]   i_position,
    input  logic signed [ols_pkg::OLS_VALUE_W-1:0] i_item_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_ok,
    output logic signed [ols_pkg::OLS_POS_W-1:0]   o_result_index,
    output logic signed [ols_pkg::OLS_VALUE_W-1:0] o_read_value,
    output logic        [ols_pkg::OLS_COUNT_W-1:0] o_removed_count,
    output logic        [ols_pkg::OLS_COUNT_W-1:0] o_item_count,
    output logic                                   o_is_empty
);
    import ols_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ols_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ols_dp #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .o_ok            (o_ok),
        .o_result_index  (o_result_index),
        .o_read_value    (o_read_value),
        .o_removed_count (o_removed_count),
        .o_item_count    (o_item_count),
        .o_is_empty      (o_is_empty)
    );

    // a pending result blocks new input
    `OLS_ASSERT_NOW(a_result_blocks_input, o_out_valid, o_in_stall, "input taken with result pending")
    // failures always report index -1
    `OLS_ASSERT_NOW(a_fail_index, o_out_valid && !o_ok, o_result_index == OLS_IDX_NONE, "failed result has an index")
    // a read value or a removal only comes with success
    `OLS_ASSERT_NOW(a_data_needs_ok, o_out_valid && (o_read_value != '0 || o_removed_count != '0), o_ok, "data on a failed result")
    // one result per item: a transferred result is gone next cycle
    `OLS_ASSERT_NEXT(a_single_result, o_out_valid && !i_out_stall, !o_out_valid, "result repeated")

endmodule
